### design/gregorian_date_arithmetic_assert.svh
// assertion macros for the date arithmetic unit
`ifndef GREGORIAN_DATE_ARITHMETIC_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GDA_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("gda assertion failed");

// next-cycle implication, disabled during reset
`define GDA_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("gda assertion failed");

`endif

### design/gda_pkg.sv
// package: types, constants and calendar functions of the date unit
`timescale 1ns / 1ps
package gda_pkg;

  localparam int MAX_YEAR = 9999;
  localparam int SER_W    = 22;
  localparam int YEAR_W   = 14;
  // last serial day: 31 Dec MAX_YEAR, counted from 1 Jan 0001
  localparam int LAST_SERIAL_I = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                                 + MAX_YEAR / 400 - 1;
  localparam logic [SER_W-1:0]  LAST_SERIAL = SER_W'(LAST_SERIAL_I);
  localparam logic [YEAR_W-1:0] MAX_YEAR_V  = YEAR_W'(MAX_YEAR);
  // reciprocals: 1/100 with 19 fraction bits, 1/366 with 32, 1/7 with 25
  localparam logic [12:0] RCP_100 = 13'd5243;
  localparam logic [23:0] RCP_366 = 24'd11734883;
  localparam logic [22:0] RCP_7   = 23'd4793491;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_DIFF = 2'd2,
    OP_WDAY = 2'd3
  } gda_op_t;

  typedef enum logic [1:0] {
    YSEL_FIRST,
    YSEL_SECOND,
    YSEL_CUR,
    YSEL_PREV
  } gda_ysel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_YEAR1,
    ST_SER1,
    ST_YEAR2,
    ST_SER2,
    ST_ARITH,
    ST_EST,
    ST_YINIT,
    ST_YSTEP,
    ST_MINIT,
    ST_MSTEP,
    ST_WDAY,
    ST_FIN
  } gda_state_t;

  typedef struct packed {
    logic      load;
    logic      year_calc;
    gda_ysel_t ysel;
    logic      ser_first;
    logic      ser_second;
    logic      arith;
    logic      est;
    logic      ystep;
    logic      minit;
    logic      mstep;
    logic      wday;
    logic      finish;
  } gda_cmd_t;

  typedef struct packed {
    gda_op_t op;
    logic    year_more;
    logic    month_more;
    logic    out_busy;
  } gda_stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                       len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the first of month m
  function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
    logic [8:0] c;
    unique case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      default: c = 9'd334;
    endcase
    if (leap && m > 4'd2) c = c + 9'd1;
    return c;
  endfunction

endpackage

### design/gda_ctrl.sv
// controller: sequences the datapath through one request
`timescale 1ns / 1ps
module gda_ctrl
  import gda_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  gda_stat_t stat,
  output gda_cmd_t  cmd
);

  gda_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_YEAR1;
      ST_YEAR1: state_next = ST_SER1;
      ST_SER1: begin
        unique case (stat.op)
          OP_DIFF: state_next = ST_YEAR2;
          OP_WDAY: state_next = ST_WDAY;
          default: state_next = ST_ARITH;
        endcase
      end
      ST_YEAR2: state_next = ST_SER2;
      ST_SER2:  state_next = ST_FIN;
      ST_ARITH: state_next = ST_EST;
      ST_EST:   state_next = ST_YINIT;
      ST_YINIT: state_next = ST_YSTEP;
      ST_YSTEP: if (!stat.year_more) state_next = ST_MINIT;
      ST_MINIT: state_next = ST_MSTEP;
      ST_MSTEP: if (!stat.month_more) state_next = ST_FIN;
      ST_WDAY:  state_next = ST_FIN;
      ST_FIN:   if (!stat.out_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.ysel = YSEL_FIRST;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_YEAR1: cmd.year_calc = 1'b1;
      ST_SER1:  cmd.ser_first = 1'b1;
      ST_YEAR2: begin
        cmd.year_calc = 1'b1;
        cmd.ysel      = YSEL_SECOND;
      end
      ST_SER2:  cmd.ser_second = 1'b1;
      ST_ARITH: cmd.arith = 1'b1;
      ST_EST:   cmd.est = 1'b1;
      ST_YINIT: begin
        cmd.year_calc = 1'b1;
        cmd.ysel      = YSEL_PREV;
      end
      ST_YSTEP: begin
        cmd.ystep = 1'b1;
        cmd.ysel  = YSEL_CUR;
      end
      ST_MINIT: cmd.minit = 1'b1;
      ST_MSTEP: cmd.mstep = 1'b1;
      ST_WDAY:  cmd.wday = 1'b1;
      ST_FIN:   cmd.finish = !stat.out_busy;
      default:  cmd = '0;
    endcase
  end

endmodule

### design/gda_datapath.sv
// datapath: serial day conversion, add/subtract, year and month search, results
`timescale 1ns / 1ps
module gda_datapath
  import gda_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  gda_cmd_t          cmd,
  output gda_stat_t         stat,
  input  logic [1:0]        op,
  input  logic [4:0]        first_day,
  input  logic [3:0]        first_month,
  input  logic [13:0]       first_year,
  input  logic [4:0]        second_day,
  input  logic [3:0]        second_month,
  input  logic [13:0]       second_year,
  input  logic [21:0]       day_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [4:0]        result_day,
  output logic [3:0]        result_month,
  output logic [13:0]       result_year,
  output logic [21:0]       day_difference,
  output logic [2:0]        weekday,
  output logic              out_of_range
);

  gda_op_t           op_r;
  logic [4:0]        d1, d2;
  logic [3:0]        m1, m2;
  logic [13:0]       y1, y2;
  logic [21:0]       cnt;
  logic [SER_W-1:0]  ys, s1, s2, rs;
  logic              leap, oor;
  logic [13:0]       yr;
  logic [3:0]        mo;
  logic [8:0]        rem;
  logic [2:0]        wd;
  logic              arith_op;

  // year unit: p = year - 1 -> serial of 1 Jan of year, leap flag of year
  logic [13:0]       yp, y_sel;
  logic [26:0]       q_prod;
  logic [7:0]        q;
  logic [13:0]       r_full;
  logic [6:0]        r100;
  logic [22:0]       ys_wide;
  logic [SER_W-1:0]  ys_u;
  logic              leap_u;

  always_comb begin
    y_sel = (cmd.ysel == YSEL_SECOND) ? y2 : y1;
    if (y_sel == 14'd0) y_sel = 14'd1;
    else if (y_sel > MAX_YEAR_V) y_sel = MAX_YEAR_V;
    unique case (cmd.ysel)
      YSEL_FIRST, YSEL_SECOND: yp = y_sel - 14'd1;
      YSEL_CUR:                yp = yr;
      default:                 yp = yr - 14'd1;
    endcase
    q_prod  = {13'd0, yp} * {14'd0, RCP_100};
    q       = q_prod[26:19];
    r_full  = yp - 14'({6'd0, q} * 14'd100);
    r100    = r_full[6:0];
    ys_wide = {9'd0, yp} * 23'd365 + {11'd0, yp[13:2]} - {15'd0, q} + {17'd0, q[7:2]};
    ys_u    = ys_wide[SER_W-1:0];
    leap_u  = (yp[1:0] == 2'd3 && r100 != 7'd99) || (r100 == 7'd99 && q[1:0] == 2'd3);
  end

  // date to serial, from the registered year start
  logic [4:0]        dsel, dc, ml;
  logic [3:0]        msel, mc;
  logic [SER_W-1:0]  ser_u;

  always_comb begin
    dsel = cmd.ser_second ? d2 : d1;
    msel = cmd.ser_second ? m2 : m1;
    mc   = (msel == 4'd0) ? 4'd1 : ((msel > 4'd12) ? 4'd12 : msel);
    ml   = month_len(mc, leap);
    dc   = (dsel == 5'd0) ? 5'd1 : ((dsel > ml) ? ml : dsel);
    ser_u = ys + {13'd0, cum_days(mc, leap)} + {17'd0, dc} - 22'd1;
  end

  // add / subtract with clamping
  logic [22:0]       sum;
  always_comb sum = {1'b0, s1} + {1'b0, cnt};

  // year estimate from serial / 366, never above the true year
  logic [45:0]       est_prod;
  always_comb est_prod = {24'd0, rs} * {22'd0, RCP_366};

  // month walk
  logic [4:0]        ml_cur;
  always_comb begin
    ml_cur          = month_len(mo, leap);
    stat.month_more = (mo < 4'd12) && (rem >= {4'd0, ml_cur});
    stat.year_more  = (ys_u <= rs);
    stat.op         = op_r;
    stat.out_busy   = out_valid && !out_ready;
  end

  // weekday: serial mod 7, reference day has residue 6
  logic [44:0]       q7_prod;
  logic [19:0]       q7;
  logic [21:0]       r7_full;
  logic [2:0]        r7;
  always_comb begin
    q7_prod = {23'd0, s1} * {22'd0, RCP_7};
    q7      = q7_prod[44:25];
    r7_full = s1 - 22'({2'd0, q7} * 22'd7);
    r7      = r7_full[2:0];
  end

  always_comb arith_op = (op_r == OP_ADD) || (op_r == OP_SUB);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= gda_op_t'(op);
      d1 <= first_day;  m1 <= first_month;  y1 <= first_year;
      d2 <= second_day; m2 <= second_month; y2 <= second_year;
      cnt <= day_count;
    end
    if (cmd.year_calc) begin
      ys   <= ys_u;
      leap <= leap_u;
    end
    if (cmd.ser_first)  s1 <= ser_u;
    if (cmd.ser_second) s2 <= ser_u;
    if (cmd.arith) begin
      if (op_r == OP_ADD) begin
        if (sum > {1'b0, LAST_SERIAL}) begin
          rs  <= LAST_SERIAL;
          oor <= 1'b1;
        end else begin
          rs  <= sum[SER_W-1:0];
          oor <= 1'b0;
        end
      end else begin
        if (cnt > s1) begin
          rs  <= '0;
          oor <= 1'b1;
        end else begin
          rs  <= s1 - cnt;
          oor <= 1'b0;
        end
      end
    end
    if (cmd.est) yr <= est_prod[45:32] + 14'd1;
    if (cmd.ystep && stat.year_more) begin
      ys   <= ys_u;
      leap <= leap_u;
      yr   <= yr + 14'd1;
    end
    if (cmd.minit) begin
      rem <= 9'(rs - ys);
      mo  <= 4'd1;
    end
    if (cmd.mstep && stat.month_more) begin
      rem <= rem - {4'd0, ml_cur};
      mo  <= mo + 4'd1;
    end
    if (cmd.wday) wd <= (r7 == 3'd6) ? 3'd0 : r7 + 3'd1;
    if (cmd.finish) begin
      // fields the op does not produce read zero
      result_day     <= arith_op ? 5'(rem + 9'd1) : '0;
      result_month   <= arith_op ? mo : '0;
      result_year    <= arith_op ? yr : '0;
      out_of_range   <= arith_op && oor;
      day_difference <= (op_r == OP_DIFF && s1 > s2) ? s1 - s2 : '0;
      weekday        <= (op_r == OP_WDAY) ? wd : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

endmodule

### design/gregorian_date_arithmetic.sv
// top level: proleptic gregorian date unit
`timescale 1ns / 1ps
// usage
// - input channel in_valid/in_ready carries one request word: op and two dates
//   plus day_count; op selects add days, subtract days, difference or weekday
// - output channel out_valid/out_ready carries one result word per request;
//   fields that the op does not produce read zero
// - a request is taken only while the unit is idle; in_ready drops for the
//   whole computation
// - from acceptance to out_valid, weekday runs YEAR1, SER1, WDAY and FIN;
//   difference runs YEAR1, SER1, YEAR2, SER2 and FIN; add/subtract runs
//   YEAR1, SER1, ARITH, EST, YINIT, the year search (one year start computed
//   per cycle, starting from serial / 366), the month walk (one month per
//   cycle) and FIN
// - the next request is taken only the cycle after the result is loaded
// - the result sits in an output register; a new request may be accepted
//   while it waits, and the next result is held back until the receiver
//   takes the old one
// - synchronous reset empties the output register and returns to idle
// - out_of_range flags an add or subtract that left years 1..MAX_YEAR; the
//   date then saturates to 31 Dec MAX_YEAR or 1 Jan 0001
module gregorian_date_arithmetic
  import gda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [4:0]  first_day,
  input  logic [3:0]  first_month,
  input  logic [13:0] first_year,
  input  logic [4:0]  second_day,
  input  logic [3:0]  second_month,
  input  logic [13:0] second_year,
  input  logic [21:0] day_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  result_day,
  output logic [3:0]  result_month,
  output logic [13:0] result_year,
  output logic [21:0] day_difference,
  output logic [2:0]  weekday,
  output logic        out_of_range
);

  `include "gregorian_date_arithmetic_assert.svh"

  gda_cmd_t  cmd;
  gda_stat_t stat;

  // state machine that steps the datapath
  gda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // conversions, arithmetic and output register
  gda_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .op             (op),
    .first_day      (first_day),
    .first_month    (first_month),
    .first_year     (first_year),
    .second_day     (second_day),
    .second_month   (second_month),
    .second_year    (second_year),
    .day_count      (day_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_day     (result_day),
    .result_month   (result_month),
    .result_year    (result_year),
    .day_difference (day_difference),
    .weekday        (weekday),
    .out_of_range   (out_of_range)
  );

  // one request at a time
  `GDA_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  // weekday stays in 0..6
  `GDA_ASSERT_IMP(a_weekday_range, clk, rst, out_valid, weekday <= 3'd6)
  // month stays in 0..12
  `GDA_ASSERT_IMP(a_month_range, clk, rst, out_valid, result_month <= 4'd12)
  // saturation lands on an end of the supported range
  `GDA_ASSERT_IMP(a_oor_saturates, clk, rst, out_valid && out_of_range,
                  result_year == 14'd1 || result_year == MAX_YEAR_V)

endmodule
